/* src/rbfe_pkg.sv */
// shared types and constants for the ring buffer frame extractor
package rbfe_pkg;

  localparam int unsigned Depth = 64;
  localparam int unsigned PtrW = $clog2(Depth);

  localparam logic [1:0] KindStored  = 2'd0;
  localparam logic [1:0] KindDropped = 2'd1;
  localparam logic [1:0] KindNone    = 2'd2;
  localparam logic [1:0] KindFrame   = 2'd3;

  localparam logic CmdWrite = 1'b0;
  localparam logic CmdGet   = 1'b1;

  localparam logic RegHeader = 1'b0;
  localparam logic RegMinBuf = 1'b1;

  typedef struct packed {
    logic       cmd;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] frame_byte;
    logic [5:0] frame_length;
    logic       last;
  } out_item_t;

  typedef enum logic [3:0] {
    StIdle, StWrite, StHdrRd, StHdrChk, StLenRd, StLenChk,
    StSumRd, StSumAcc, StChkCmp, StEmitRd, StEmit, StNone
  } state_e;

endpackage

/* src/rbfe_ram.sv */
// generic single-port-write ram with registered read
module rbfe_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* src/rbfe_fifo.sv */
// small queue of items between front and back
module rbfe_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  rbfe_pkg::in_item_t  data_i,
  output logic                full_o,
  input  logic                pop_i,
  output rbfe_pkg::in_item_t  data_o,
  output logic                empty_o
);

  rbfe_pkg::in_item_t mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = mem_q[rp_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) begin
      mem_q[wp_q] <= data_i;
    end
  end

  // pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i && !full_o) wp_q <= ~wp_q;
      if (pop_i && !empty_o) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'((push_i && !full_o) ? 1 : 0) - 2'((pop_i && !empty_o) ? 1 : 0);
    end
  end

endmodule

/* src/rbfe_back.sv */
// sequencer that stores bytes, scans for frames and emits results
module rbfe_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                avail_i,
  input  rbfe_pkg::in_item_t  item_i,
  output logic                take_o,
  input  logic [7:0]          header_i,
  input  logic [5:0]          min_buf_i,
  output logic                res_valid_o,
  output rbfe_pkg::out_item_t res_o,
  input  logic                res_ready_i
);

  localparam int unsigned PW = rbfe_pkg::PtrW;

  rbfe_pkg::state_e state_q, state_d;
  logic [PW-1:0] rp_q, rp_d, wp_q, wp_d;
  logic [PW-1:0] off_q, off_d;
  logic [PW:0]   len_q, len_d;
  logic [7:0]    sum_q, sum_d;
  logic [7:0]    data_q, data_d;
  logic          drop_q, drop_d;

  logic          we;
  logic [PW-1:0] raddr;
  logic [7:0]    rdata;
  logic [PW-1:0] count;
  logic [PW:0]   thresh;
  logic [PW-1:0] len_lo;

  assign count  = wp_q - rp_q;
  assign thresh = (min_buf_i < 6'd2) ? (PW+1)'(2) : (PW+1)'(min_buf_i);
  assign len_lo = len_q[PW-1:0];

  rbfe_ram #(.Width(8), .Depth(rbfe_pkg::Depth)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(wp_q),
    .wdata_i(data_q),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    rp_d = rp_q; wp_d = wp_q; off_d = off_q; len_d = len_q;
    sum_d = sum_q; data_d = data_q; drop_d = drop_q;
    case (state_q)
      rbfe_pkg::StIdle: begin
        if (avail_i) begin
          data_d = item_i.data_byte;
          if (item_i.cmd == rbfe_pkg::CmdWrite) begin
            drop_d  = (count == PW'(rbfe_pkg::Depth - 1));
            state_d = rbfe_pkg::StWrite;
          end else begin
            state_d = rbfe_pkg::StHdrRd;
          end
        end
      end
      rbfe_pkg::StWrite: begin
        if (res_ready_i) begin
          if (!drop_q) wp_d = wp_q + PW'(1);
          state_d = rbfe_pkg::StIdle;
        end
      end
      rbfe_pkg::StHdrRd: begin
        if ((PW+1)'(count) < thresh) state_d = rbfe_pkg::StNone;
        else state_d = rbfe_pkg::StHdrChk;
      end
      rbfe_pkg::StHdrChk: begin
        if (rdata != header_i) begin
          rp_d = rp_q + PW'(1);
          state_d = rbfe_pkg::StHdrRd;
        end else begin
          state_d = rbfe_pkg::StLenRd;
        end
      end
      rbfe_pkg::StLenRd: state_d = rbfe_pkg::StLenChk;
      rbfe_pkg::StLenChk: begin
        if (rdata < 8'd2 || rdata > 8'(rbfe_pkg::Depth - 1)) begin
          rp_d = rp_q + PW'(1);
          state_d = rbfe_pkg::StHdrRd;
        end else if ((PW+1)'(count) < rdata[PW:0]) begin
          state_d = rbfe_pkg::StNone;
        end else begin
          len_d = rdata[PW:0];
          off_d = '0;
          sum_d = '0;
          state_d = rbfe_pkg::StSumRd;
        end
      end
      rbfe_pkg::StSumRd: state_d = rbfe_pkg::StSumAcc;
      rbfe_pkg::StSumAcc: begin
        if (off_q == len_lo - PW'(1)) begin
          state_d = rbfe_pkg::StChkCmp;
        end else begin
          sum_d = sum_q + rdata;
          off_d = off_q + PW'(1);
          state_d = rbfe_pkg::StSumRd;
        end
      end
      rbfe_pkg::StChkCmp: begin
        if (sum_q != rdata) begin
          rp_d = rp_q + PW'(1);
          state_d = rbfe_pkg::StHdrRd;
        end else begin
          off_d = '0;
          state_d = rbfe_pkg::StEmitRd;
        end
      end
      rbfe_pkg::StEmitRd: state_d = rbfe_pkg::StEmit;
      rbfe_pkg::StEmit: begin
        if (res_ready_i) begin
          if (off_q == len_lo - PW'(1)) begin
            rp_d = rp_q + len_lo;
            state_d = rbfe_pkg::StIdle;
          end else begin
            off_d = off_q + PW'(1);
            state_d = rbfe_pkg::StEmitRd;
          end
        end
      end
      rbfe_pkg::StNone: begin
        if (res_ready_i) state_d = rbfe_pkg::StIdle;
      end
      default: state_d = rbfe_pkg::StIdle;
    endcase
  end

  // outputs
  always_comb begin
    take_o = 1'b0;
    we = 1'b0;
    res_valid_o = 1'b0;
    res_o = '0;
    res_o.last = 1'b1;
    raddr = rp_q;
    case (state_q)
      rbfe_pkg::StIdle: take_o = avail_i;
      rbfe_pkg::StWrite: begin
        res_valid_o = 1'b1;
        res_o.kind = drop_q ? rbfe_pkg::KindDropped : rbfe_pkg::KindStored;
        we = res_ready_i && !drop_q;
      end
      rbfe_pkg::StLenRd: raddr = rp_q + PW'(1);
      // keep the address steady so the read data holds while waiting
      rbfe_pkg::StSumRd, rbfe_pkg::StSumAcc, rbfe_pkg::StEmitRd: raddr = rp_q + off_q;
      rbfe_pkg::StEmit: begin
        raddr = rp_q + off_q;
        res_valid_o = 1'b1;
        res_o.kind = rbfe_pkg::KindFrame;
        res_o.frame_byte = rdata;
        res_o.frame_length = 6'(len_q);
        res_o.last = (off_q == len_lo - PW'(1));
      end
      rbfe_pkg::StNone: begin
        res_valid_o = 1'b1;
        res_o.kind = rbfe_pkg::KindNone;
      end
      default: ;
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rbfe_pkg::StIdle;
      rp_q <= '0;
      wp_q <= '0;
    end else begin
      state_q <= state_d;
      rp_q <= rp_d;
      wp_q <= wp_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    off_q <= off_d; len_q <= len_d; sum_q <= sum_d;
    data_q <= data_d; drop_q <= drop_d;
  end

endmodule

/* src/ring_buffer_frame_extractor.sv */
// top level of the ring buffer frame extractor
// A write item takes the sequencer from idle to the write state, which offers its
// result to the result side. A get item walks the buffer through the single
// registered read port of the byte ram: a header read and check per byte
// discarded as a non-header, also a length read and check for a bad length, a
// read and accumulate step per checksummed byte and a read and emit step per
// emitted frame byte. A full result side stalls the sequencer. Items queue in
// a two-entry input queue and results in a two-entry output queue; the user is
// to write configuration only while the block is idle, not enforced by the block.
module ring_buffer_frame_extractor (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  input  rbfe_pkg::in_item_t  in_item_i,
  output logic                full,
  output logic                empty,
  input  logic                pop,
  output rbfe_pkg::out_item_t out_item_o,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_index_i,
  input  logic [7:0]          cfg_data_i
);

  logic               avail_n, take;
  rbfe_pkg::in_item_t item;
  logic               res_valid, res_ready;
  rbfe_pkg::out_item_t res;
  logic [7:0]         header_q;
  logic [5:0]         min_buf_q;
  rbfe_pkg::out_item_t ob_q [2];
  logic               ob_wp_q, ob_rp_q;
  logic [1:0]         ob_cnt_q;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q  <= 8'hAA;
      min_buf_q <= 6'd4;
    end else if (cfg_valid) begin
      if (cfg_index_i == rbfe_pkg::RegHeader) header_q <= cfg_data_i;
      else min_buf_q <= cfg_data_i[5:0];
    end
  end

  rbfe_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (in_item_i),
    .full_o (full),
    .pop_i  (take),
    .data_o (item),
    .empty_o(avail_n)
  );

  rbfe_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .avail_i    (!avail_n),
    .item_i     (item),
    .take_o     (take),
    .header_i   (header_q),
    .min_buf_i  (min_buf_q),
    .res_valid_o(res_valid),
    .res_o      (res),
    .res_ready_i(res_ready)
  );

  // result queue
  assign res_ready  = (ob_cnt_q != 2'd2);
  assign empty      = (ob_cnt_q == 2'd0);
  assign out_item_o = ob_q[ob_rp_q];

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) ob_q[ob_wp_q] <= res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ob_wp_q <= 1'b0; ob_rp_q <= 1'b0; ob_cnt_q <= 2'd0;
    end else begin
      if (res_valid && res_ready) ob_wp_q <= ~ob_wp_q;
      if (pop && !empty) ob_rp_q <= ~ob_rp_q;
      ob_cnt_q <= ob_cnt_q + 2'((res_valid && res_ready) ? 1 : 0)
                - 2'((pop && !empty) ? 1 : 0);
    end
  end

endmodule

/* bench/tb_ring_buffer_frame_extractor.sv */
// testbench for the ring buffer frame extractor: scoreboard against a behavioral frame parser
module tb_ring_buffer_frame_extractor;

  localparam int unsigned Depth = rbfe_pkg::Depth;
  localparam int unsigned PW = rbfe_pkg::PtrW;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  rbfe_pkg::in_item_t in_item_i = '0;
  logic full, empty, cfg_ready;
  logic pop = 1'b0;
  rbfe_pkg::out_item_t out_item_o;
  logic cfg_valid = 1'b0;
  logic cfg_index_i = rbfe_pkg::RegHeader;
  logic [7:0] cfg_data_i = '0;

  ring_buffer_frame_extractor u_dut (
    .clk_i, .rst_ni, .push, .in_item_i, .full, .empty, .pop, .out_item_o,
    .cfg_valid, .cfg_ready, .cfg_index_i, .cfg_data_i
  );

  // clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // parser model state
  logic [7:0] ring_q [Depth];
  logic [PW-1:0] rd_ptr, wr_ptr;
  logic [7:0] hdr_val;
  logic [5:0] min_wait;

  rbfe_pkg::in_item_t  pending_items [$];
  rbfe_pkg::out_item_t expected_results [$];
  int errors = 0;
  int send_idle = 27;
  int recv_idle = 49;
  bit recv_hold = 1'b0;
  bit hold_start = 1'b0;
  bit hold_done = 1'b0;

  function automatic logic [7:0] peek_at(int off);
    logic [PW-1:0] p;
    p = rd_ptr + PW'(off);
    return ring_q[p];
  endfunction

  function automatic rbfe_pkg::out_item_t make_res(logic [1:0] k, logic [7:0] b,
                                                   logic [5:0] l, logic lst);
    rbfe_pkg::out_item_t r;
    r.kind = k; r.frame_byte = b; r.frame_length = l; r.last = lst;
    return r;
  endfunction

  // work out the results of one accepted item
  task automatic parse_item(rbfe_pkg::in_item_t it);
    int cnt, thr, len;
    logic [7:0] sum;
    bit found;
    thr = (min_wait < 6'd2) ? 2 : int'(min_wait);
    found = 1'b0;
    if (it.cmd == rbfe_pkg::CmdWrite) begin
      if (int'(PW'(wr_ptr - rd_ptr)) >= int'(Depth) - 1) begin
        expected_results.push_back(make_res(rbfe_pkg::KindDropped, 8'd0, 6'd0, 1'b1));
      end else begin
        ring_q[wr_ptr] = it.data_byte;
        wr_ptr = wr_ptr + PW'(1);
        expected_results.push_back(make_res(rbfe_pkg::KindStored, 8'd0, 6'd0, 1'b1));
      end
      return;
    end
    for (int g = 0; g <= int'(Depth); g++) begin
      cnt = int'(PW'(wr_ptr - rd_ptr));
      if (cnt < thr) break;
      if (peek_at(0) != hdr_val) begin
        rd_ptr = rd_ptr + PW'(1);
        continue;
      end
      len = int'(peek_at(1));
      if (len < 2 || len > int'(Depth) - 1) begin
        rd_ptr = rd_ptr + PW'(1);
        continue;
      end
      if (cnt < len) break;
      sum = '0;
      for (int i = 0; i + 1 < len; i++) sum = sum + peek_at(i);
      if (sum != peek_at(len - 1)) begin
        rd_ptr = rd_ptr + PW'(1);
        continue;
      end
      for (int i = 0; i < len; i++)
        expected_results.push_back(make_res(rbfe_pkg::KindFrame, peek_at(i), 6'(len),
                                            i + 1 == len));
      rd_ptr = rd_ptr + PW'(len);
      found = 1'b1;
      break;
    end
    if (!found) expected_results.push_back(make_res(rbfe_pkg::KindNone, 8'd0, 6'd0, 1'b1));
  endtask

  task automatic report_mismatch(string what, rbfe_pkg::out_item_t got,
                                 rbfe_pkg::out_item_t want);
    errors++;
    $display("mismatch %s: got k=%0d b=%02h l=%0d last=%0d want k=%0d b=%02h l=%0d last=%0d",
             what, got.kind, got.frame_byte, got.frame_length, got.last,
             want.kind, want.frame_byte, want.frame_length, want.last);
  endtask

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && !full) begin
        parse_item(in_item_i);
        void'(pending_items.pop_front());
      end
      if (pending_items.size() > 0 && ($urandom_range(99) >= send_idle)) begin
        push <= 1'b1;
        in_item_i <= pending_items[0];
      end else begin
        push <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop && !empty) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected", out_item_o, '0);
        end else begin
          if (out_item_o !== expected_results[0])
            report_mismatch("field", out_item_o, expected_results[0]);
          void'(expected_results.pop_front());
        end
      end
      pop <= !recv_hold && ($urandom_range(99) >= recv_idle);
    end
  end

  // long receiver hold, counted in its own process
  initial begin
    wait (hold_start);
    recv_hold = 1'b1;
    repeat (600) @(posedge clk_i);
    recv_hold = 1'b0;
    hold_done = 1'b1;
  end

  // wait until everything queued has gone through
  task automatic drain();
    while (pending_items.size() > 0 || push || expected_results.size() > 0)
      @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [7:0] val);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == rbfe_pkg::RegHeader) hdr_val = val;
    else min_wait = val[5:0];
  endtask

  function automatic rbfe_pkg::in_item_t wr(logic [7:0] b);
    rbfe_pkg::in_item_t it;
    it.cmd = rbfe_pkg::CmdWrite; it.data_byte = b;
    return it;
  endfunction

  function automatic rbfe_pkg::in_item_t get_req();
    rbfe_pkg::in_item_t it;
    it.cmd = rbfe_pkg::CmdGet; it.data_byte = 8'($urandom_range(255));
    return it;
  endfunction

  // queue a frame of at least three bytes, optionally with a broken checksum
  task automatic add_frame(int len, bit bad);
    logic [7:0] sum, b;
    sum = hdr_val + 8'(len);
    pending_items.push_back(wr(hdr_val));
    pending_items.push_back(wr(8'(len)));
    for (int i = 2; i < len - 1; i++) begin
      b = 8'($urandom_range(255));
      sum = sum + b;
      pending_items.push_back(wr(b));
    end
    pending_items.push_back(wr(bad ? sum ^ 8'h01 : sum));
  endtask

  task automatic random_phase(int n);
    int r, len;
    for (int k = 0; k < n; ) begin
      r = $urandom_range(9);
      if (r < 6) begin
        len = $urandom_range(3, 9);
        add_frame(len, $urandom_range(4) == 0);
        pending_items.push_back(get_req());
        k += len + 1;
      end else if (r < 8) begin
        pending_items.push_back(wr(8'($urandom_range(255))));
        k++;
      end else begin
        pending_items.push_back(get_req());
        k++;
      end
    end
    drain();
  endtask

  initial begin
    foreach (ring_q[i]) ring_q[i] = '0;
    rd_ptr = '0; wr_ptr = '0; hdr_val = 8'hAA; min_wait = 6'd4;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    write_reg(rbfe_pkg::RegMinBuf, 8'd2);
    // longest frame with a zero header while the receiver holds off,
    // then writes into the full ring and a request for the frame
    write_reg(rbfe_pkg::RegHeader, 8'h00);
    hold_start = 1'b1;
    add_frame(63, 1'b0);
    for (int i = 0; i < 3; i++) pending_items.push_back(wr(8'($urandom_range(255))));
    pending_items.push_back(get_req());
    wait (hold_done);
    drain();
    // threshold extremes
    write_reg(rbfe_pkg::RegMinBuf, 8'd63);
    pending_items.push_back(get_req());
    drain();
    write_reg(rbfe_pkg::RegMinBuf, 8'd0);
    pending_items.push_back(get_req());
    drain();
    // directed: empty request, shortest frame, bad lengths, incomplete frame
    write_reg(rbfe_pkg::RegHeader, 8'hAA);
    write_reg(rbfe_pkg::RegMinBuf, 8'd2);
    pending_items.push_back(get_req());
    add_frame(3, 1'b0);
    pending_items.push_back(get_req());
    pending_items.push_back(wr(8'h00));
    pending_items.push_back(wr(8'hAA));
    pending_items.push_back(wr(8'h01));
    pending_items.push_back(wr(8'hAA));
    pending_items.push_back(wr(8'hFF));
    pending_items.push_back(wr(8'hAA));
    pending_items.push_back(wr(8'h08));
    pending_items.push_back(get_req());
    add_frame(4, 1'b1);
    pending_items.push_back(get_req());
    drain();
    write_reg(rbfe_pkg::RegHeader, 8'hFF);
    write_reg(rbfe_pkg::RegMinBuf, 8'd4);
    send_idle = 27; recv_idle = 49;
    random_phase(6);
    write_reg(rbfe_pkg::RegHeader, 8'($urandom_range(255)));
    send_idle = 49; recv_idle = 27;
    random_phase(6);
    write_reg(rbfe_pkg::RegMinBuf, 8'($urandom_range(2, 8)));
    send_idle = 0; recv_idle = 0;
    random_phase(6);
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  // overall timeout
  initial begin
    #20000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
